// File: rtl/otci_pkg.sv
// Package with shared types, codes and constants for the omega table interpolation unit.
`timescale 1ns / 1ps
`default_nettype none
package otci_pkg;

  localparam int unsigned CMD_W   = 1;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned Q_W     = 32;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_EVAL = 1'b1;

  localparam logic [CFG_A_W-1:0] REG_LOW_THRESHOLD = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_LOW_OMEGA     = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_LOW_SIGMA     = 2'd2;

  localparam logic [CFG_W-1:0] LOW_THRESHOLD_RST = 31'd50063;
  localparam logic [CFG_W-1:0] LOW_OMEGA_RST     = 31'd66257;
  localparam logic [CFG_W-1:0] LOW_SIGMA_RST     = 31'd53458;

  localparam logic signed [Q_W-1:0] Q_ONE = 32'sd65536;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // Region of the query found by the front end.
  typedef enum logic [1:0] {
    RG_EXTRAP = 2'd0,
    RG_LOW    = 2'd1,
    RG_CUBIC  = 2'd2,
    RG_NONE   = 2'd3
  } region_t;

  // Back-end sequencer operations.
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NOP = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SCAN,
    FS_READ,
    FS_PUSH
  } fstate_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_RUN,
    BS_DIV,
    BS_OUT
  } bstate_t;

  typedef struct packed {
    region_t           region;
    logic signed [Q_W-1:0] q;
    logic signed [Q_W-1:0] sin_v;
    logic signed [Q_W-1:0] x0, x1, x2, x3;
    logic signed [Q_W-1:0] o0, o1, o2, o3;
    logic signed [Q_W-1:0] s0, s1, s2, s3;
  } job_t;

  typedef struct packed {
    logic signed [Q_W-1:0] omega;
    status_t               status;
  } res_t;

  function automatic logic signed [Q_W-1:0] sat64(input logic signed [65:0] v,
                                                   output logic sat);
    sat = 1'b0;
    if (v > 66'sh0_7FFF_FFFF) begin
      sat = 1'b1;
      return Q_MAX;
    end
    if (v < -66'sh0_8000_0000) begin
      sat = 1'b1;
      return Q_MIN;
    end
    return v[Q_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/otci_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface otci_in_if;
  import otci_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [IDX_W-1:0]        entry_index;
  logic signed [Q_W-1:0]   node_ratio;
  logic signed [Q_W-1:0]   node_omega;
  logic signed [Q_W-1:0]   node_sigma;
  logic signed [Q_W-1:0]   shields_ratio;
  logic signed [Q_W-1:0]   sigma_in;
  modport source (output valid, command, entry_index, node_ratio, node_omega, node_sigma,
                  shields_ratio, sigma_in, input ready);
  modport sink (input valid, command, entry_index, node_ratio, node_omega, node_sigma,
                shields_ratio, sigma_in, output ready);
endinterface

interface otci_out_if;
  import otci_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] omega_out;
  logic [STAT_W-1:0]     status;
  modport source (output valid, omega_out, status, input ready);
  modport sink (input valid, omega_out, status, output ready);
endinterface

interface otci_cfg_if;
  import otci_pkg::*;
  logic                valid;
  logic                ready;
  logic [CFG_A_W-1:0]  index;
  logic [Q_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/otci_front.sv
// Front end: table storage, load handling, interval search and node fetch.
`timescale 1ns / 1ps
`default_nettype none
module otci_front #(
  parameter int unsigned TABLE_ENTRIES = 37
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  otci_in_if.sink                           in_ch,
  input  wire logic [otci_pkg::CFG_W-1:0]   low_threshold,
  output      otci_pkg::job_t               job,
  output      logic                         job_valid,
  input  wire logic                         job_ready
);
  import otci_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  logic signed [Q_W-1:0] ratio_mem [TABLE_ENTRIES];
  logic signed [Q_W-1:0] omega_mem [TABLE_ENTRIES];
  logic signed [Q_W-1:0] sigma_mem [TABLE_ENTRIES];

  fstate_t state, state_next;
  logic [AW-1:0] addr, addr_next;
  logic [2:0]    cnt, cnt_next;
  logic signed [Q_W-1:0] rd_r, rd_o, rd_s;
  logic signed [Q_W-1:0] prev_r;
  logic signed [Q_W-1:0] top_r;
  job_t jb, jb_next;
  logic in_fire;
  logic wr_en;
  logic [AW-1:0] rd_addr;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign wr_en   = in_fire && in_ch.command == CMD_LOAD &&
                   {1'b0, in_ch.entry_index} < 7'(TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ratio_mem[in_ch.entry_index[AW-1:0]] <= in_ch.node_ratio;
      omega_mem[in_ch.entry_index[AW-1:0]] <= in_ch.node_omega;
      sigma_mem[in_ch.entry_index[AW-1:0]] <= in_ch.node_sigma;
    end
    rd_r <= ratio_mem[rd_addr];
    rd_o <= omega_mem[rd_addr];
    rd_s <= sigma_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
    addr  <= addr_next;
    cnt   <= cnt_next;
    jb    <= jb_next;
    prev_r <= (state == FS_SCAN && cnt != 3'd0) ? rd_r : prev_r;
  end

  assign top_r = rd_r;

  always_comb begin
    state_next  = state;
    addr_next   = addr;
    cnt_next    = cnt;
    jb_next     = jb;
    rd_addr     = addr;
    in_ch.ready = 1'b0;
    job_valid   = 1'b0;
    case (state)
      FS_IDLE: begin
        in_ch.ready = 1'b1;
        rd_addr     = AW'(TABLE_ENTRIES - 2);
        if (in_fire && in_ch.command == CMD_EVAL) begin
          jb_next.q     = in_ch.shields_ratio;
          jb_next.sin_v = in_ch.sigma_in;
          addr_next     = AW'(TABLE_ENTRIES - 2);
          cnt_next      = 3'd0;
          state_next    = FS_SCAN;
        end
      end
      FS_SCAN: begin
        // cnt 0: rd holds entry N-2; afterwards rd holds entry addr-1 walking up.
        if (cnt == 3'd0) begin
          if (jb.q > top_r) begin
            jb_next.region = RG_EXTRAP;
            addr_next  = AW'(TABLE_ENTRIES - 2);
            rd_addr    = AW'(TABLE_ENTRIES - 2);
            cnt_next   = 3'd0;
            state_next = FS_READ;
          end else if ($signed({jb.q[Q_W-1], jb.q}) <= $signed({2'b00, low_threshold})) begin
            jb_next.region = RG_LOW;
            state_next = FS_PUSH;
          end else begin
            rd_addr   = AW'(1);
            addr_next = AW'(2);
            cnt_next  = 3'd1;
          end
        end else if (cnt == 3'd1) begin
          rd_addr   = addr;
          addr_next = addr + AW'(1);
          cnt_next  = 3'd2;
        end else begin
          // prev_r is entry addr-2 (= i), rd_r is entry i+1.
          if (jb.q > prev_r && jb.q <= rd_r) begin
            jb_next.region = RG_CUBIC;
            addr_next  = addr - AW'(3);
            rd_addr    = addr - AW'(3);
            cnt_next   = 3'd0;
            state_next = FS_READ;
          end else if (addr - AW'(1) >= AW'(TABLE_ENTRIES - 2)) begin
            jb_next.region = RG_NONE;
            state_next = FS_PUSH;
          end else begin
            rd_addr   = addr;
            addr_next = addr + AW'(1);
          end
        end
      end
      FS_READ: begin
        // Entry addr arrives this cycle while the next entry is read.
        rd_addr = addr + AW'(1);
        case (cnt)
          3'd0: begin jb_next.x0 = rd_r; jb_next.o0 = rd_o; jb_next.s0 = rd_s; end
          3'd1: begin jb_next.x1 = rd_r; jb_next.o1 = rd_o; jb_next.s1 = rd_s; end
          3'd2: begin jb_next.x2 = rd_r; jb_next.o2 = rd_o; jb_next.s2 = rd_s; end
          default: begin jb_next.x3 = rd_r; jb_next.o3 = rd_o; jb_next.s3 = rd_s; end
        endcase
        addr_next = addr + AW'(1);
        cnt_next  = cnt + 3'd1;
        if ((jb.region == RG_CUBIC && cnt == 3'd3) ||
            (jb.region == RG_EXTRAP && cnt == 3'd1)) begin
          state_next = FS_PUSH;
        end
      end
      FS_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) state_next = FS_IDLE;
      end
      default: state_next = FS_IDLE;
    endcase
  end

  assign job = jb;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != FS_IDLE |-> !in_ch.ready) else $error("front accepted while busy");
  a_push_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid) else $error("job dropped");
  a_scan_enter: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.command == CMD_EVAL |=> state == FS_SCAN) else $error("eval not scanned");
`endif
endmodule
`default_nettype wire

// File: rtl/otci_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module otci_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire otci_pkg::job_t in_job,
  input  wire logic     in_valid,
  output      logic     in_ready,
  output otci_pkg::job_t out_job,
  output      logic     out_valid,
  input  wire logic     out_ready
);
  import otci_pkg::*;

  job_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_job   = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_job;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !out_ready |=> count == 2'd2) else $error("queue lost entry");
  a_empty_ok: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !out_valid) else $error("valid from empty queue");
`endif
endmodule
`default_nettype wire

// File: rtl/otci_back.sv
// Back end: microcoded Q16.16 arithmetic sequencer with iterative divider.
`timescale 1ns / 1ps
`default_nettype none
module otci_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire otci_pkg::job_t             job,
  input  wire logic                       job_valid,
  output      logic                       job_ready,
  input  wire logic [otci_pkg::CFG_W-1:0] low_omega,
  input  wire logic [otci_pkg::CFG_W-1:0] low_sigma,
  otci_out_if.source                      out_ch
);
  import otci_pkg::*;

  // Register file: 0..3 x, 4..7 omega-y, 8..11 sigma-y, 12 q, 13 sin, 14 one,
  // 15..31 temporaries.
  localparam int unsigned RN = 32;
  typedef logic [4:0] ra_t;
  typedef struct packed { op_t op; ra_t d; ra_t a; ra_t b; } uop_t;

  bstate_t state, state_next;
  logic signed [Q_W-1:0] rf [RN];
  logic [5:0] pc;
  logic [5:0] pc_end;
  logic div0, sat;
  uop_t u;
  logic signed [Q_W-1:0] va, vb;
  logic signed [65:0] wide;
  logic signed [Q_W-1:0] alu_res;
  logic alu_sat;
  logic ysel;
  // divider
  logic [5:0]  dcnt;
  logic [47:0] dnum;
  logic [31:0] dden;
  logic [48:0] drem;
  logic [47:0] dquo;
  logic        dneg;
  logic signed [49:0] dq_s;
  logic signed [Q_W-1:0] dres;
  logic dsat;
  logic [48:0] trial;

  function automatic uop_t prog(input logic [5:0] p);
    uop_t m;
    m = '{OP_NOP, 5'd0, 5'd0, 5'd0};
    case (p)
      // Newton cubic on y at 4..7 (omega) or 8..11 (sigma) via the ysel remap.
      6'd0:  m = '{OP_SUB, 5'd15, 5'd5, 5'd4};
      6'd1:  m = '{OP_SUB, 5'd16, 5'd1, 5'd0};
      6'd2:  m = '{OP_DIV, 5'd17, 5'd15, 5'd16};   // a2
      6'd3:  m = '{OP_SUB, 5'd18, 5'd2, 5'd0};     // d1
      6'd4:  m = '{OP_SUB, 5'd19, 5'd2, 5'd1};     // d2
      6'd5:  m = '{OP_SUB, 5'd20, 5'd6, 5'd4};
      6'd6:  m = '{OP_MUL, 5'd21, 5'd17, 5'd18};
      6'd7:  m = '{OP_SUB, 5'd20, 5'd20, 5'd21};
      6'd8:  m = '{OP_MUL, 5'd21, 5'd18, 5'd19};
      6'd9:  m = '{OP_DIV, 5'd22, 5'd20, 5'd21};   // a3
      6'd10: m = '{OP_SUB, 5'd18, 5'd3, 5'd0};     // e1
      6'd11: m = '{OP_SUB, 5'd19, 5'd3, 5'd1};     // e2
      6'd12: m = '{OP_SUB, 5'd23, 5'd3, 5'd2};     // e3
      6'd13: m = '{OP_SUB, 5'd20, 5'd7, 5'd4};
      6'd14: m = '{OP_MUL, 5'd21, 5'd17, 5'd18};
      6'd15: m = '{OP_SUB, 5'd20, 5'd20, 5'd21};
      6'd16: m = '{OP_MUL, 5'd21, 5'd22, 5'd18};
      6'd17: m = '{OP_MUL, 5'd21, 5'd21, 5'd19};
      6'd18: m = '{OP_SUB, 5'd20, 5'd20, 5'd21};   // n4
      6'd19: m = '{OP_MUL, 5'd21, 5'd18, 5'd19};
      6'd20: m = '{OP_MUL, 5'd21, 5'd21, 5'd23};
      6'd21: m = '{OP_DIV, 5'd24, 5'd20, 5'd21};   // a4
      6'd22: m = '{OP_SUB, 5'd25, 5'd12, 5'd0};    // t1
      6'd23: m = '{OP_SUB, 5'd26, 5'd12, 5'd1};    // t2
      6'd24: m = '{OP_SUB, 5'd27, 5'd12, 5'd2};    // t3
      6'd25: m = '{OP_MUL, 5'd21, 5'd17, 5'd25};
      6'd26: m = '{OP_ADD, 5'd28, 5'd4, 5'd21};
      6'd27: m = '{OP_MUL, 5'd21, 5'd22, 5'd25};
      6'd28: m = '{OP_MUL, 5'd21, 5'd21, 5'd26};
      6'd29: m = '{OP_ADD, 5'd28, 5'd28, 5'd21};
      6'd30: m = '{OP_MUL, 5'd21, 5'd24, 5'd25};
      6'd31: m = '{OP_MUL, 5'd21, 5'd21, 5'd26};
      6'd32: m = '{OP_MUL, 5'd21, 5'd21, 5'd27};
      6'd33: m = '{OP_ADD, 5'd28, 5'd28, 5'd21};   // result to 28
      // Linear: y at 4,5 ; x at 0,1.
      6'd40: m = '{OP_SUB, 5'd15, 5'd5, 5'd4};
      6'd41: m = '{OP_SUB, 5'd16, 5'd1, 5'd0};
      6'd42: m = '{OP_DIV, 5'd17, 5'd15, 5'd16};
      6'd43: m = '{OP_SUB, 5'd18, 5'd12, 5'd0};
      6'd44: m = '{OP_MUL, 5'd21, 5'd17, 5'd18};
      6'd45: m = '{OP_ADD, 5'd28, 5'd4, 5'd21};
      // Final: om in 29, sg in 30.
      6'd50: m = '{OP_DIV, 5'd15, 5'd13, 5'd30};
      6'd51: m = '{OP_SUB, 5'd16, 5'd29, 5'd14};
      6'd52: m = '{OP_MUL, 5'd17, 5'd15, 5'd16};
      6'd53: m = '{OP_ADD, 5'd31, 5'd14, 5'd17};
      default: m = '{OP_NOP, 5'd0, 5'd0, 5'd0};
    endcase
    return m;
  endfunction

  assign u = prog(pc);

  // y registers 4..7 are remapped to 8..11 for the sigma pass.
  function automatic ra_t remap(input ra_t r, input logic s);
    return (s && r >= 5'd4 && r <= 5'd7) ? r + 5'd4 : r;
  endfunction

  assign va = rf[remap(u.a, ysel)];
  assign vb = rf[remap(u.b, ysel)];

  always_comb begin
    wide = '0;
    case (u.op)
      OP_ADD: wide = 66'(va) + 66'(vb);
      OP_SUB: wide = 66'(va) - 66'(vb);
      OP_MUL: wide = 66'(64'(va) * 64'(vb)) >>> 16;
      default: wide = '0;
    endcase
    alu_res = sat64(wide, alu_sat);
  end

  assign trial = {drem[47:0], dnum[47]} - {17'd0, dden};
  assign dq_s  = dneg ? -$signed({2'b00, dquo}) : $signed({2'b00, dquo});
  always_comb dres = sat64(66'(dq_s), dsat);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      BS_IDLE: if (job_valid) begin
        rf[0] <= job.x0; rf[1] <= job.x1; rf[2] <= job.x2; rf[3] <= job.x3;
        rf[4] <= job.o0; rf[5] <= job.o1; rf[6] <= job.o2; rf[7] <= job.o3;
        rf[8] <= job.s0; rf[9] <= job.s1; rf[10] <= job.s2; rf[11] <= job.s3;
        rf[12] <= job.q; rf[13] <= job.sin_v; rf[14] <= Q_ONE;
        rf[29] <= '0; rf[30] <= '0;
        div0 <= 1'b0; sat <= 1'b0; ysel <= 1'b0;
        case (job.region)
          RG_LOW: begin
            rf[29] <= {1'b0, low_omega}; rf[30] <= {1'b0, low_sigma};
            pc <= 6'd50;
          end
          RG_EXTRAP: pc <= 6'd40;
          RG_CUBIC:  pc <= 6'd0;
          default:   pc <= 6'd50;
        endcase
        pc_end <= (job.region == RG_CUBIC) ? 6'd33 : 6'd45;
      end
      BS_RUN: begin
        if (u.op == OP_DIV) begin
          dneg <= va[Q_W-1] ^ vb[Q_W-1];
          dnum <= {(va[Q_W-1] ? 32'(-va) : 32'(va)), 16'd0};
          dden <= vb[Q_W-1] ? 32'(-vb) : 32'(vb);
          drem <= '0;
          dquo <= '0;
          dcnt <= 6'd48;
          if (vb == '0) begin
            div0 <= 1'b1;
            rf[u.d] <= va[Q_W-1] ? Q_MIN : Q_MAX;
            dcnt <= 6'd0;
          end
        end else if (u.op != OP_NOP) begin
          rf[u.d] <= alu_res;
          if (alu_sat) sat <= 1'b1;
        end
        if (u.op == OP_DIV && vb != '0) begin
          pc <= pc;
        end else if (pc == 6'd53) begin
          pc <= pc;
        end else if (pc == pc_end) begin
          if (pc == 6'd33 || pc == 6'd45) begin
            if (!ysel) rf[29] <= alu_res;
            else rf[30] <= alu_res;
          end
          if (!ysel) begin
            ysel <= 1'b1;
            pc <= (pc_end == 6'd33) ? 6'd0 : 6'd40;
          end else begin
            pc <= 6'd50;
          end
        end else begin
          pc <= pc + 6'd1;
        end
      end
      BS_DIV: begin
        if (dcnt != 6'd0) begin
          dnum <= {dnum[46:0], 1'b0};
          if (!trial[48]) begin
            drem <= trial;
            dquo <= {dquo[46:0], 1'b1};
          end else begin
            drem <= {drem[47:0], dnum[47]};
            dquo <= {dquo[46:0], 1'b0};
          end
          dcnt <= dcnt - 6'd1;
        end else begin
          rf[u.d] <= dres;
          if (dsat) sat <= 1'b1;
          pc <= pc + 6'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state)
      BS_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) state_next = BS_RUN;
      end
      BS_RUN: begin
        if (u.op == OP_DIV && vb != '0) state_next = BS_DIV;
        else if (u.op == OP_DIV) state_next = BS_RUN;
        else if (pc == 6'd53) state_next = BS_OUT;
      end
      BS_DIV: if (dcnt == 6'd0) state_next = BS_RUN;
      BS_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) state_next = BS_IDLE;
      end
      default: state_next = BS_IDLE;
    endcase
  end

  // A zero divisor skips the divider; advance pc on that path too.
  assign out_ch.omega_out = rf[31];
  assign out_ch.status    = div0 ? ST_DIV0 : (sat ? ST_SAT : ST_OK);

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.omega_out))
    else $error("result changed while stalled");
  a_idle_take: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> state == BS_IDLE) else $error("job taken while busy");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == BS_DIV |-> dcnt <= 6'd48) else $error("divider count out of range");
`endif
endmodule
`default_nettype wire

// File: rtl/omega_table_cubic_interp_unit.sv
// Top level of the omega table cubic interpolation unit.
// The front end scans the ratio table one entry per cycle and fetches the nodes; the back end
// then runs the low-region, extrapolation or cubic microcode, each divide on the iterative divider.
// Each part works on one evaluate at a time; the front end takes loads only while it is idle.
// Reset clears control state and restores the three configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module omega_table_cubic_interp_unit #(
  parameter int unsigned TABLE_ENTRIES = 37
) (
  input wire logic   clk,
  input wire logic   rst,
  otci_in_if.sink    in_ch,
  otci_out_if.source out_ch,
  otci_cfg_if.sink   cfg
);
  import otci_pkg::*;

  logic [CFG_W-1:0] low_threshold, low_omega, low_sigma;
  job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold <= LOW_THRESHOLD_RST;
      low_omega     <= LOW_OMEGA_RST;
      low_sigma     <= LOW_SIGMA_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LOW_THRESHOLD: low_threshold <= cfg.data[CFG_W-1:0];
        REG_LOW_OMEGA:     low_omega     <= cfg.data[CFG_W-1:0];
        REG_LOW_SIGMA:     low_sigma     <= cfg.data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  otci_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk, .rst, .in_ch, .low_threshold,
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  otci_queue u_queue (
    .clk, .rst, .in_job(f_job), .in_valid(f_valid), .in_ready(f_ready),
    .out_job(q_job), .out_valid(q_valid), .out_ready(q_ready)
  );

  otci_back u_back (
    .clk, .rst, .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
    .low_omega, .low_sigma, .out_ch
  );

`ifndef SYNTHESIS
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg.ready)
    else $error("config port stalled");
  a_rst_thr: assert property (@(posedge clk) $past(rst) |-> low_threshold == LOW_THRESHOLD_RST)
    else $error("threshold not reset");
  a_rst_om: assert property (@(posedge clk) $past(rst) |-> low_omega == LOW_OMEGA_RST)
    else $error("low omega not reset");
`endif
endmodule
`default_nettype wire

// File: verif/tb_omega_table_cubic_interp_unit.sv
// Self-checking testbench for the omega table cubic interpolation unit.
`timescale 1ns / 1ps
module tb_omega_table_cubic_interp_unit;
  import otci_pkg::*;

  localparam int NODES = 37;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic [CFG_A_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic signed [31:0] nr, no, ns, q, sin;
  } word_t;

  logic clk, rst;
  otci_in_if in_ch();
  otci_out_if out_ch();
  otci_cfg_if cfg();

  omega_table_cubic_interp_unit #(.TABLE_ENTRIES(NODES)) i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  word_t pend_words[$];
  res_t omega_exp[$];
  int mismatches = 0;
  int n_in_acc = 0;
  int idle_cycles = 0;

  // Shadow state of the block.
  logic signed [31:0] sh_ratio[NODES], sh_omega[NODES], sh_sigma[NODES];
  logic [CFG_W-1:0] sh_thr, sh_lomega, sh_lsigma;
  bit f_div0, f_sat;

  // Generator copy of the loaded abscissas.
  logic signed [31:0] gen_ratio[NODES];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(SMAX)) begin
      f_sat = 1;
      return SMAX;
    end
    if (v < longint'(SMIN)) begin
      f_sat = 1;
      return SMIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_add(input logic signed [31:0] a, b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] q_sub(input logic signed [31:0] a, b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a, b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> 16);
  endfunction

  function automatic logic signed [31:0] q_div(input logic signed [31:0] a, b);
    if (b == 0) begin
      f_div0 = 1;
      return (a >= 0) ? SMAX : SMIN;
    end
    return clamp32((longint'(a) * 65536) / longint'(b));
  endfunction

  function automatic logic signed [31:0] cubic4(input logic signed [31:0] x0, x1, x2, x3,
                                                 input logic signed [31:0] y0, y1, y2, y3,
                                                 input logic signed [31:0] q);
    logic signed [31:0] a2, d1, d2, a3, e1, e2, e3, n4, a4, t1, t2, t3, r;
    a2 = q_div(q_sub(y1, y0), q_sub(x1, x0));
    d1 = q_sub(x2, x0);
    d2 = q_sub(x2, x1);
    a3 = q_div(q_sub(q_sub(y2, y0), q_mul(a2, d1)), q_mul(d1, d2));
    e1 = q_sub(x3, x0);
    e2 = q_sub(x3, x1);
    e3 = q_sub(x3, x2);
    n4 = q_sub(q_sub(q_sub(y3, y0), q_mul(a2, e1)), q_mul(q_mul(a3, e1), e2));
    a4 = q_div(n4, q_mul(q_mul(e1, e2), e3));
    t1 = q_sub(q, x0);
    t2 = q_sub(q, x1);
    t3 = q_sub(q, x2);
    r = q_add(y0, q_mul(a2, t1));
    r = q_add(r, q_mul(q_mul(a3, t1), t2));
    r = q_add(r, q_mul(q_mul(q_mul(a4, t1), t2), t3));
    return r;
  endfunction

  function automatic logic signed [31:0] line2(input logic signed [31:0] y0, y1, x0, x1, q);
    return q_add(y0, q_mul(q_div(q_sub(y1, y0), q_sub(x1, x0)), q_sub(q, x0)));
  endfunction

  function automatic res_t predict_omega(input logic signed [31:0] q, sin);
    logic signed [31:0] om, sg;
    res_t r;
    f_div0 = 0;
    f_sat = 0;
    om = 0;
    sg = 0;
    if (q > sh_ratio[NODES-2]) begin
      om = line2(sh_omega[NODES-2], sh_omega[NODES-1], sh_ratio[NODES-2], sh_ratio[NODES-1], q);
      sg = line2(sh_sigma[NODES-2], sh_sigma[NODES-1], sh_ratio[NODES-2], sh_ratio[NODES-1], q);
    end else if (longint'(q) <= longint'(sh_thr)) begin
      om = {1'b0, sh_lomega};
      sg = {1'b0, sh_lsigma};
    end else begin
      for (int i = 1; i <= NODES - 3; i++) begin
        if (q > sh_ratio[i] && q <= sh_ratio[i+1]) begin
          om = cubic4(sh_ratio[i-1], sh_ratio[i], sh_ratio[i+1], sh_ratio[i+2],
                      sh_omega[i-1], sh_omega[i], sh_omega[i+1], sh_omega[i+2], q);
          sg = cubic4(sh_ratio[i-1], sh_ratio[i], sh_ratio[i+1], sh_ratio[i+2],
                      sh_sigma[i-1], sh_sigma[i], sh_sigma[i+1], sh_sigma[i+2], q);
          break;
        end
      end
    end
    r.omega = q_add(Q_ONE, q_mul(q_div(sin, sg), q_sub(om, Q_ONE)));
    r.status = f_div0 ? ST_DIV0 : (f_sat ? ST_SAT : ST_OK);
    return r;
  endfunction

  // Clock and reset.
  initial begin
    clk = 0;
    rst = 1;
    in_ch.valid = 0;
    in_ch.command = CMD_LOAD;
    in_ch.entry_index = 0;
    in_ch.node_ratio = 0;
    in_ch.node_omega = 0;
    in_ch.node_sigma = 0;
    in_ch.shields_ratio = 0;
    in_ch.sigma_in = 0;
    out_ch.ready = 0;
    cfg.valid = 0;
    cfg.index = REG_LOW_THRESHOLD;
    cfg.data = 0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (8) @(posedge clk);
        rst <= 0;
      end
    join_none
  end

  // Driver.
  int burst_left = 1, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 0;
      end else if (pend_words.size() > 0) begin
        word_t w;
        w = pend_words.pop_front();
        in_ch.valid <= 1;
        in_ch.command <= w.cmd;
        in_ch.entry_index <= w.idx;
        in_ch.node_ratio <= w.nr;
        in_ch.node_omega <= w.no;
        in_ch.node_sigma <= w.ns;
        in_ch.shields_ratio <= w.q;
        in_ch.sigma_in <= w.sin;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Receiver with its own stall pattern and one long hold-off.
  int rx_mode = 0, rx_tick = 0, hold_left = 0;
  bit held = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 128 == 0) rx_mode <= $urandom_range(0, 2);
      if (!held && n_in_acc >= 700) begin
        held <= 1;
        hold_left <= 3000;
        out_ch.ready <= 0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 0;
      end else begin
        case (rx_mode)
          0: out_ch.ready <= 1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor: predicts on accepted words and checks results.
  always @(posedge clk) begin
    if (!rst) begin
      bit any;
      any = 0;
      if (cfg.valid && cfg.ready) begin
        any = 1;
        case (cfg.index)
          REG_LOW_THRESHOLD: sh_thr = cfg.data[CFG_W-1:0];
          REG_LOW_OMEGA: sh_lomega = cfg.data[CFG_W-1:0];
          REG_LOW_SIGMA: sh_lsigma = cfg.data[CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        any = 1;
        n_in_acc++;
        if (in_ch.command == CMD_LOAD) begin
          if (in_ch.entry_index < NODES) begin
            sh_ratio[in_ch.entry_index] = in_ch.node_ratio;
            sh_omega[in_ch.entry_index] = in_ch.node_omega;
            sh_sigma[in_ch.entry_index] = in_ch.node_sigma;
          end
        end else begin
          omega_exp.push_back(predict_omega(in_ch.shields_ratio, in_ch.sigma_in));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        any = 1;
        if (omega_exp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result word: omega %h status %0d", out_ch.omega_out,
                     out_ch.status);
        end else begin
          res_t e;
          e = omega_exp.pop_front();
          if (out_ch.omega_out !== e.omega || out_ch.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected omega %h status %0d, got omega %h status %0d",
                       e.omega, e.status, out_ch.omega_out, out_ch.status);
          end
        end
      end
      idle_cycles = any ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rnd_q();
    return $signed($urandom());
  endfunction

  function automatic word_t load_word(input int idx, input logic signed [31:0] r, o, s);
    word_t w;
    w.cmd = CMD_LOAD;
    w.idx = IDX_W'(idx);
    w.nr = r;
    w.no = o;
    w.ns = s;
    w.q = rnd_q();
    w.sin = rnd_q();
    return w;
  endfunction

  function automatic word_t eval_word(input logic signed [31:0] q, sin);
    word_t w;
    w.cmd = CMD_EVAL;
    w.idx = IDX_W'($urandom_range(0, 63));
    w.nr = rnd_q();
    w.no = rnd_q();
    w.ns = rnd_q();
    w.q = q;
    w.sin = sin;
    return w;
  endfunction

  task automatic load_table(input bit noisy);
    logic signed [31:0] r;
    r = $signed(32'($urandom_range(0, 100000))) - 32'sd65536;
    for (int i = 0; i < NODES; i++) begin
      if (noisy) begin
        gen_ratio[i] = rnd_q();
        pend_words.push_back(load_word(i, gen_ratio[i], rnd_q(), rnd_q()));
      end else begin
        r = r + $urandom_range(1000, 40000);
        gen_ratio[i] = r;
        pend_words.push_back(load_word(i, r,
          $signed(32'($urandom_range(0, 8 << 16))) - (32'sd4 <<< 16),
          ($urandom_range(0, 15) == 0) ? 32'sd0 : 32'($urandom_range(13000, 3 << 16))));
      end
    end
  endtask

  function automatic logic signed [31:0] pick_query();
    case ($urandom_range(0, 9))
      0: return rnd_q();
      1: return gen_ratio[$urandom_range(0, NODES-1)];
      2: return gen_ratio[$urandom_range(0, NODES-1)] + $signed(32'($urandom_range(0, 2))) - 1;
      3: return ($urandom_range(0, 1) == 0) ? SMAX : SMIN;
      4: return {1'b0, sh_thr} + $signed(32'($urandom_range(0, 2))) - 1;
      default: return gen_ratio[0] - 20000 + $signed(32'($urandom_range(0,
                 32'(gen_ratio[NODES-1] - gen_ratio[0]) + 200000)));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_sigma_in();
    case ($urandom_range(0, 7))
      0: return rnd_q();
      1: return 0;
      default: return $signed(32'($urandom_range(0, 8 << 16))) - (32'sd4 <<< 16);
    endcase
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pend_words.size() != 0 || in_ch.valid || omega_exp.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [31:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk);
    while (!cfg.ready);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] thr_set[6], lom_set[6], lsg_set[6];
    sh_thr = LOW_THRESHOLD_RST;
    sh_lomega = LOW_OMEGA_RST;
    sh_lsigma = LOW_SIGMA_RST;
    thr_set = '{32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'd50063, 32'h8000_0000, 32'd200000};
    lom_set = '{32'h0, 32'h7FFF_FFFF, 32'h8001_0000, 32'd66257, 32'h0002_0000, 32'hFFFF_FFFF};
    lsg_set = '{32'h0, 32'h7FFF_FFFF, 32'h0000_8000, 32'd53458, 32'h8000_0000, 32'd1};
    @(negedge rst);
    @(posedge clk);

    load_table(0);
    pend_words.push_back(load_word(37, rnd_q(), rnd_q(), rnd_q()));
    pend_words.push_back(load_word(63, rnd_q(), rnd_q(), rnd_q()));
    pend_words.push_back(eval_word(SMIN, 32'sd65536));
    pend_words.push_back(eval_word(SMAX, 32'sd65536));
    pend_words.push_back(eval_word(0, SMAX));
    pend_words.push_back(eval_word(32'sd50063, SMIN));
    pend_words.push_back(eval_word(32'sd50064, 32'sd65536));
    pend_words.push_back(eval_word(gen_ratio[NODES-2], 32'sd65536));
    pend_words.push_back(eval_word(gen_ratio[NODES-2] + 1, 32'sd65536));
    pend_words.push_back(eval_word(gen_ratio[NODES-1] + 500000, 32'sd65536));
    pend_words.push_back(eval_word(gen_ratio[1], 0));
    pend_words.push_back(eval_word(gen_ratio[1] + 1, 32'sd65536));
    pend_words.push_back(eval_word(gen_ratio[10], -32'sd65536));
    pend_words.push_back(eval_word(gen_ratio[20] + 3, SMAX));
    pend_words.push_back(eval_word(gen_ratio[NODES-3] + 1, 32'sd131072));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_LOW_THRESHOLD, thr_set[ph]);
      write_reg(REG_LOW_OMEGA, lom_set[ph]);
      write_reg(REG_LOW_SIGMA, lsg_set[ph]);
      if (ph == 2) write_reg(REG_UNUSED, $urandom());
      load_table(ph == 4);
      for (int k = 0; k < 200; k++) begin
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
          pend_words.push_back(load_word($urandom_range(0, 63), rnd_q(), rnd_q(), rnd_q()));
        end else if (r < 4) begin
          int e;
          e = $urandom_range(0, NODES-1);
          pend_words.push_back(load_word(e, gen_ratio[e], rnd_q() >>> $urandom_range(0, 14),
                                         rnd_q() >>> $urandom_range(0, 14)));
        end else begin
          pend_words.push_back(eval_word(pick_query(), pick_sigma_in()));
        end
      end
      wait_idle();
    end

    if (mismatches == 0 && omega_exp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
